[design/zbw_pkg.sv]
// Package: shared types, constants and state encoding for the zoom blur block.
`default_nettype none
package zbw_pkg;

  localparam int MaxWidthDef  = 256;
  localparam int MaxHeightDef = 256;
  localparam int CfgIdxW      = 3;

  localparam logic [CfgIdxW-1:0] REG_WIDTH    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CX       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CY       = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_STRENGTH = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_MODE     = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_FACTOR   = 3'd6;

  localparam logic       CMD_LOAD    = 1'b0;
  localparam logic       CMD_BLUR    = 1'b1;
  localparam logic [1:0] MODE_TANGENT = 2'd1;
  localparam logic [1:0] MODE_SPIRAL  = 2'd2;

  typedef struct packed {
    logic       command;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } zbw_in_t;

  typedef struct packed {
    logic [7:0] out_col;
    logic [7:0] out_row;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       status;
  } zbw_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_DIVX, ST_SETUP, ST_ADDR, ST_READ, ST_ACC,
    ST_AVG, ST_SRC, ST_SRCR, ST_SRCW, ST_DIVC, ST_DONE
  } zbw_state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic store_wr;
    logic div_start;
    logic div_avg;
    logic setup;
    logic addr;
    logic acc;
    logic src_addr;
    logic src_take;
    logic emit;
  } zbw_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_load;
    logic div_done;
    logic last;
    logic in_frame;
    logic stop;
    logic zero_cnt;
  } zbw_sts_t;

endpackage
`default_nettype wire

[design/zbw_ctrl.sv]
// Controller: sequences load, step division, sample walk, and average or source pixel read.
`default_nettype none
module zbw_ctrl import zbw_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire zbw_sts_t sts,
  output zbw_cmd_t      cmd
);

  zbw_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = sts.is_load ? ST_IDLE : ST_DIVX;
      ST_DIVX:  if (sts.div_done) state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = ST_ADDR;
      ST_ADDR:  state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_ACC;
      ST_ACC: begin
        if (sts.stop || sts.last) state_nxt = sts.zero_cnt ? ST_SRC : ST_AVG;
        else state_nxt = ST_ADDR;
      end
      ST_AVG:   state_nxt = ST_DIVC;
      ST_SRC:   state_nxt = ST_SRCR;
      ST_SRCR:  state_nxt = ST_SRCW;
      ST_SRCW:  state_nxt = ST_DONE;
      ST_DIVC:  if (sts.div_done) state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE:  cmd.capture = start;
      ST_LOAD: begin
        cmd.store_wr  = sts.is_load;
        cmd.div_start = !sts.is_load;
      end
      ST_SETUP: cmd.setup = 1'b1;
      ST_ADDR:  cmd.addr = 1'b1;
      ST_ACC:   cmd.acc = 1'b1;
      // sums include the last sample by now
      ST_AVG: begin
        cmd.div_start = 1'b1;
        cmd.div_avg   = 1'b1;
      end
      ST_SRC:   cmd.src_addr = 1'b1;
      ST_SRCW:  cmd.src_take = 1'b1;
      ST_DONE:  cmd.emit = 1'b1;
      default:  cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

[design/zbw_div.sv]
// Restoring divider: three lanes of unsigned quotient, one bit per cycle.
`default_nettype none
module zbw_div import zbw_pkg::*; #(
  parameter int NumW = 22
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [NumW-1:0] num_a,
  input  wire logic [NumW-1:0] num_b,
  input  wire logic [NumW-1:0] num_c,
  input  wire logic [6:0]      den,
  output logic                 done,
  output logic [NumW-1:0]      quo_a,
  output logic [NumW-1:0]      quo_b,
  output logic [NumW-1:0]      quo_c
);

  localparam int CntW = $clog2(NumW + 1);

  logic [CntW-1:0] cnt_r;
  logic            run_r;
  logic [7:0]      rem_a_r, rem_b_r, rem_c_r;
  logic [6:0]      den_r;
  logic [7:0]      ta, tb, tc;

  assign ta = {rem_a_r[6:0], quo_a[NumW-1]};
  assign tb = {rem_b_r[6:0], quo_b[NumW-1]};
  assign tc = {rem_c_r[6:0], quo_c[NumW-1]};
  assign done = run_r && (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= CntW'(NumW);
    end else if (run_r) begin
      if (cnt_r == '0) run_r <= 1'b0;
      else cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_a <= num_a; quo_b <= num_b; quo_c <= num_c;
      rem_a_r <= '0; rem_b_r <= '0; rem_c_r <= '0;
      den_r <= den;
    end else if (run_r && cnt_r != '0) begin
      if (ta >= {1'b0, den_r}) begin
        rem_a_r <= ta - {1'b0, den_r}; quo_a <= {quo_a[NumW-2:0], 1'b1};
      end else begin
        rem_a_r <= ta; quo_a <= {quo_a[NumW-2:0], 1'b0};
      end
      if (tb >= {1'b0, den_r}) begin
        rem_b_r <= tb - {1'b0, den_r}; quo_b <= {quo_b[NumW-2:0], 1'b1};
      end else begin
        rem_b_r <= tb; quo_b <= {quo_b[NumW-2:0], 1'b0};
      end
      if (tc >= {1'b0, den_r}) begin
        rem_c_r <= tc - {1'b0, den_r}; quo_c <= {quo_c[NumW-2:0], 1'b1};
      end else begin
        rem_c_r <= tc; quo_c <= {quo_c[NumW-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

[design/zbw_dp.sv]
// Datapath: config registers, frame store, step walk and channel sums.
`default_nettype none
module zbw_dp import zbw_pkg::*; #(
  parameter int MAX_WIDTH  = MaxWidthDef,
  parameter int MAX_HEIGHT = MaxHeightDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [13:0]        cfg_data,
  input  wire zbw_in_t            in_data,
  input  wire zbw_cmd_t           cmd,
  output zbw_sts_t                sts,
  output zbw_out_t                out_data
);

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(Depth);
  localparam int QW    = 22;   // |fac*d| < 2^22
  localparam int PW    = 32;   // signed 24.8 walk positions

  logic [8:0]  width_r, height_r;
  logic [7:0]  cx_r, cy_r;
  logic [6:0]  str_r;
  logic [1:0]  mode_r;
  logic [13:0] fac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 9'd256; height_r <= 9'd256; cx_r <= 8'd128; cy_r <= 8'd128;
      str_r <= 7'd10; mode_r <= 2'd0; fac_r <= 14'd7;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:    width_r  <= cfg_data[8:0];
        REG_HEIGHT:   height_r <= cfg_data[8:0];
        REG_CX:       cx_r     <= cfg_data[7:0];
        REG_CY:       cy_r     <= cfg_data[7:0];
        REG_STRENGTH: str_r    <= cfg_data[6:0];
        REG_MODE:     mode_r   <= cfg_data[1:0];
        REG_FACTOR:   fac_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective frame limits and divisor
  logic [12:0] w_eff, h_eff;
  logic [6:0]  s_eff;
  always_comb begin
    w_eff = (width_r == '0) ? 13'd1 :
            ({4'd0, width_r} > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : {4'd0, width_r};
    h_eff = (height_r == '0) ? 13'd1 :
            ({4'd0, height_r} > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : {4'd0, height_r};
    s_eff = (str_r == '0) ? 7'd1 : str_r;
  end

  zbw_in_t req_r;
  always_ff @(posedge clk) if (cmd.capture) req_r <= in_data;

  logic req_in_store;
  assign req_in_store = (32'(req_r.col) < MAX_WIDTH) && (32'(req_r.row) < MAX_HEIGHT);

  // frame store, addressed row*MAX_WIDTH+col
  logic [23:0] mem [Depth];
  logic [23:0] rd_r;
  logic [AW-1:0] rd_addr_r;
  logic [AW-1:0] wr_addr;
  assign wr_addr = AW'(req_r.row) * AW'(MAX_WIDTH) + AW'(req_r.col);

  always_ff @(posedge clk) begin
    if (cmd.store_wr && req_in_store)
      mem[wr_addr] <= {req_r.in_red, req_r.in_green, req_r.in_blue};
    rd_r <= mem[rd_addr_r];
  end

  // step division: |fac*d| / s, sign restored afterwards
  logic signed [8:0] dx, dy;
  logic [QW-1:0] ax, ay, qx, qy, qc0, q_r, q_g, q_b;
  logic [22:0]   px, py;
  logic          div_done;
  logic [QW-1:0] sum_r_r, sum_g_r, sum_b_r;
  logic [6:0]    cnt_r;

  assign dx = $signed({1'b0, req_r.col}) - $signed({1'b0, cx_r});
  assign dy = $signed({1'b0, req_r.row}) - $signed({1'b0, cy_r});
  assign px = 23'(fac_r) * 23'(dx[8] ? -dx : dx);
  assign py = 23'(fac_r) * 23'(dy[8] ? -dy : dy);
  assign ax = px[QW-1:0];
  assign ay = py[QW-1:0];

  zbw_div #(.NumW(QW)) u_div (
    .clk, .rst_n,
    .start (cmd.div_start),
    .num_a (cmd.div_avg ? sum_r_r : ax),
    .num_b (cmd.div_avg ? sum_g_r : ay),
    .num_c (cmd.div_avg ? sum_b_r : '0),
    .den   (cmd.div_avg ? cnt_r : s_eff),
    .done  (div_done),
    .quo_a (qx), .quo_b (qy), .quo_c (qc0)
  );
  assign q_r = qx; assign q_g = qy; assign q_b = qc0;

  // which divide is running: step or average
  logic avg_r;
  always_ff @(posedge clk) if (cmd.div_start) avg_r <= cmd.div_avg;

  logic signed [PW-1:0] ddx, ddy;
  assign ddx = dx[8] ? -$signed(PW'(qx)) : $signed(PW'(qx));
  assign ddy = dy[8] ? -$signed(PW'(qy)) : $signed(PW'(qy));

  // walk
  logic signed [PW-1:0] nx_r, ny_r, sx_r, sy_r;
  logic [6:0]  k_r;
  logic        radial;
  logic signed [PW-1:0] cxs, cys;
  assign radial = (mode_r != MODE_TANGENT) && (mode_r != MODE_SPIRAL);
  assign cxs = nx_r >>> 8;
  assign cys = ny_r >>> 8;

  logic inside_r;
  logic signed [PW-1:0] bx, by, sxv, syv, ddxs, ddys;
  assign ddxs = ddx * $signed({25'd0, s_eff});
  assign ddys = ddy * $signed({25'd0, s_eff});
  always_comb begin
    bx = $signed({16'd0, req_r.col, 8'd128});
    by = $signed({16'd0, req_r.row, 8'd128});
    if (mode_r == MODE_TANGENT) begin
      bx = bx + ddys; by = by - ddxs; sxv = -ddy; syv = ddx;
    end else if (mode_r == MODE_SPIRAL) begin
      bx = bx - ddys; by = by - ddxs; sxv = ddy; syv = ddx;
    end else begin
      bx = bx - ddxs; by = by - ddys; sxv = ddx; syv = ddy;
    end
  end

  logic [7:0] res_r, res_g, res_b;
  logic       status_r;

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      nx_r <= bx; ny_r <= by; sx_r <= sxv; sy_r <= syv;
      k_r <= '0; cnt_r <= '0;
      sum_r_r <= '0; sum_g_r <= '0; sum_b_r <= '0;
    end
    if (cmd.addr) begin
      inside_r <= (cxs >= 0) && (cxs < $signed({19'd0, w_eff})) &&
                  (cys >= 0) && (cys < $signed({19'd0, h_eff}));
      rd_addr_r <= AW'(cys) * AW'(MAX_WIDTH) + AW'(cxs);
    end
    if (cmd.acc) begin
      if (inside_r) begin
        sum_r_r <= sum_r_r + QW'(rd_r[23:16]);
        sum_g_r <= sum_g_r + QW'(rd_r[15:8]);
        sum_b_r <= sum_b_r + QW'(rd_r[7:0]);
        cnt_r <= cnt_r + 1'b1;
      end
      nx_r <= nx_r + sx_r; ny_r <= ny_r + sy_r;
      k_r <= k_r + 1'b1;
    end
    if (cmd.src_addr) rd_addr_r <= wr_addr;
    if (cmd.src_take) begin
      res_r <= req_in_store ? rd_r[23:16] : 8'd0;
      res_g <= req_in_store ? rd_r[15:8]  : 8'd0;
      res_b <= req_in_store ? rd_r[7:0]   : 8'd0;
      status_r <= 1'b1;
    end
    if (div_done && avg_r) begin
      res_r <= (q_r > QW'(255)) ? 8'd255 : q_r[7:0];
      res_g <= (q_g > QW'(255)) ? 8'd255 : q_g[7:0];
      res_b <= (q_b > QW'(255)) ? 8'd255 : q_b[7:0];
      status_r <= 1'b0;
    end
  end

  assign sts.is_load  = (req_r.command == CMD_LOAD);
  assign sts.div_done = div_done;
  assign sts.last     = (k_r + 1'b1) == s_eff;
  assign sts.in_frame = inside_r;
  assign sts.stop     = radial && !inside_r;
  assign sts.zero_cnt = (cnt_r == '0) && !inside_r;

  always_comb begin
    out_data.out_col   = req_r.col;
    out_data.out_row   = req_r.row;
    out_data.out_red   = res_r;
    out_data.out_green = res_g;
    out_data.out_blue  = res_b;
    out_data.status    = status_r;
  end

endmodule
`default_nettype wire

[design/zoom_blur_warp.sv]
// Top level of the zoom blur block: controller, datapath and ports.
//   channel | handshake          | payload
//   in      | start / busy       | in_data (zbw_in_t)
//   out     | out_valid strobe   | out_data (zbw_out_t)
//   cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
// A load holds busy only in the load state after the request is taken. A compute holds busy
// through decode, the step divide and setup, then for each of n samples walked (at most strength):
// address, store read and accumulate, then the average divide and the result.
// With no sample in frame a source pixel read (address, read, take) replaces the divide.
// Synchronous active-low reset clears control and config; the frame store is not cleared.
// The result strobe lasts one cycle; the receiver cannot stall, so nothing waits on it.
`default_nettype none
module zoom_blur_warp import zbw_pkg::*; #(
  parameter int MAX_WIDTH  = MaxWidthDef,
  parameter int MAX_HEIGHT = MaxHeightDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire zbw_in_t            in_data,
  output logic                    out_valid,
  output zbw_out_t                out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [13:0]        cfg_data
);

  zbw_cmd_t cmd;
  zbw_sts_t sts;

  assign cfg_ready = 1'b1;

  zbw_ctrl u_ctrl (.clk, .rst_n, .start, .busy, .sts, .cmd);

  zbw_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data, .in_data,
    .cmd, .sts, .out_data
  );

  assign out_valid = cmd.emit;

endmodule
`default_nettype wire

[design/zbw_checker.sv]
// Port-level checker for the zoom blur block, bound to the top level.
`default_nettype none
module zbw_checker import zbw_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     out_valid,
  input wire zbw_in_t  in_data
);
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result without request in flight");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted request not taken");
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("strobe longer than one cycle");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy after result");
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.command == CMD_LOAD) |=> !out_valid)
    else $error("result for a load request");
endmodule

bind zoom_blur_warp zbw_checker u_chk (.clk, .rst_n, .start, .busy, .out_valid,
  .in_data);
`default_nettype wire
